// ===== rtl/hsp_pkg.sv =====
// ---------------------------------------------------------------------------
// hsp_pkg: shared types and arithmetic helpers for the HSL palette scaler
// Sideband record, divider step and constant dividers by 255 and 60.
// ---------------------------------------------------------------------------
package hsp_pkg;

    localparam int DivStages = 4;

    // Hue sector base, picked by the channel that holds the maximum
    typedef enum logic [1:0] {
        BASE_RED   = 2'd0,
        BASE_GREEN = 2'd1,
        BASE_BLUE  = 2'd2
    } t_base;

    // Per-item data that rides alongside the divider
    typedef struct packed {
        logic [7:0] idx;
        logic       last;
        logic       gray;
        logic [7:0] red;
        logic [8:0] sum;
        logic       hneg;
        t_base      hbase;
    } t_side;

    // Partial state of one restoring division
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] low;
        logic [7:0] quo;
    } t_dstep;

    // Two restoring division steps (two quotient bits)
    function automatic t_dstep div_two(input t_dstep s, input logic [7:0] den);
        t_dstep     o;
        logic [8:0] t;
        o = s;
        for (int k = 0; k < 2; k++) begin
            t     = {o.rem, o.low[7]};
            o.low = {o.low[6:0], 1'b0};
            if (t >= {1'b0, den}) begin
                t     = t - {1'b0, den};
                o.quo = {o.quo[6:0], 1'b1};
            end else begin
                o.quo = {o.quo[6:0], 1'b0};
            end
            o.rem = t[7:0];
        end
        return o;
    endfunction

    // floor(x / 255) for x below 2^18: reciprocal estimate, one correction
    function automatic logic [9:0] div255(input logic [17:0] x);
        logic [26:0] prod;
        logic [9:0]  q;
        logic [17:0] r;
        prod = {9'd0, x} + {1'b0, x, 8'd0};
        q    = prod[25:16];
        r    = x - ({q, 8'd0} - {8'd0, q});
        if (r >= 18'd255) begin
            q = q + 10'd1;
        end
        return q;
    endfunction

    // Signed x / 60 truncating toward zero, |x| below 2^17
    function automatic logic signed [11:0] div60s(input logic signed [17:0] x);
        logic [16:0] mag;
        logic [14:0] y;
        logic [31:0] prod;
        logic [10:0] q;
        logic [14:0] r;
        mag  = x[17] ? 17'(-x) : x[16:0];
        y    = mag[16:2];
        prod = {17'd0, y} * 32'd4369;
        q    = prod[26:16];
        r    = y - 15'(q * 11'd15);
        if (r >= 15'd15) begin
            q = q + 11'd1;
        end
        return x[17] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

endpackage

// ===== rtl/hsl_palette_scaler.sv =====
// ---------------------------------------------------------------------------
// hsl_palette_scaler: per-color hue, saturation and lightness scaling
// RGB to integer HSL, scale each by a factor over 255, back to RGB.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one palette color with its
//   index and last mark; output channel (o_out_valid / i_out_ready) returns
//   the adjusted color with index and last mark unchanged.
//   Scales are written on the plain write port: index 0 hue, 1 saturation,
//   2 lightness; other indexes are ignored. Write only while idle.
//   Throughput: one color per cycle while the output is not stalled; the
//   pipeline is 13 register stages and the saturation and hue quotients
//   come from a 4-stage twin divider.
//   Reset clears all valid bits and sets every scale to 255.
//   When the receiver stalls, the whole pipeline holds in place and
//   o_in_ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module hsl_palette_scaler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_color_index,
    input  logic       i_last_in_range,
    input  logic [7:0] i_src_red,
    input  logic [7:0] i_src_green,
    input  logic [7:0] i_src_blue,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_index,
    output logic       o_out_last,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    localparam logic [1:0] RegHue   = 2'd0;
    localparam logic [1:0] RegSat   = 2'd1;
    localparam logic [1:0] RegLight = 2'd2;

    typedef enum logic [1:0] {
        RGN_UP   = 2'd0,
        RGN_HI   = 2'd1,
        RGN_DOWN = 2'd2,
        RGN_LO   = 2'd3
    } t_rgn;

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Configuration registers
    logic [7:0] r_hue_scale, r_sat_scale, r_light_scale;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_scale   <= 8'd255;
            r_sat_scale   <= 8'd255;
            r_light_scale <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegHue:   r_hue_scale   <= i_cfg_data;
                RegSat:   r_sat_scale   <= i_cfg_data;
                RegLight: r_light_scale <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Valid bits of stages outside the divider
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh, r_vi;
    logic w_vdiv;

    // ---- Stage A: capture request
    logic [7:0] r_a_idx, r_a_r, r_a_g, r_a_b;
    logic       r_a_last;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_idx  <= i_color_index;
            r_a_last <= i_last_in_range;
            r_a_r    <= i_src_red;
            r_a_g    <= i_src_green;
            r_a_b    <= i_src_blue;
        end
    end

    // ---- Stage B: max, min, divider operands
    logic [7:0]  a_hi, a_lo, a_diff;
    logic [8:0]  a_sum, a_inv;
    logic [8:0]  a_hd;
    logic [7:0]  a_hmag;
    logic [15:0] a_num_s, a_num_h;
    logic [7:0]  a_den_s, a_den_h;
    hsp_pkg::t_side a_side;

    always_comb begin
        a_hi   = (r_a_r > r_a_g) ? r_a_r : r_a_g;
        a_hi   = (a_hi > r_a_b) ? a_hi : r_a_b;
        a_lo   = (r_a_r < r_a_g) ? r_a_r : r_a_g;
        a_lo   = (a_lo < r_a_b) ? a_lo : r_a_b;
        a_diff = a_hi - a_lo;
        a_sum  = {1'b0, a_hi} + {1'b0, a_lo};
        a_inv  = 9'd510 - a_sum;
        a_side.idx  = r_a_idx;
        a_side.last = r_a_last;
        a_side.gray = (a_diff == 8'd0);
        a_side.red  = r_a_r;
        a_side.sum  = a_sum;
        if (r_a_r == a_hi) begin
            a_hd         = {1'b0, r_a_g} - {1'b0, r_a_b};
            a_side.hbase = hsp_pkg::BASE_RED;
        end else if (r_a_g == a_hi) begin
            a_hd         = {1'b0, r_a_b} - {1'b0, r_a_r};
            a_side.hbase = hsp_pkg::BASE_GREEN;
        end else begin
            a_hd         = {1'b0, r_a_r} - {1'b0, r_a_g};
            a_side.hbase = hsp_pkg::BASE_BLUE;
        end
        a_side.hneg = a_hd[8];
        a_hmag      = a_hd[8] ? 8'(-a_hd) : a_hd[7:0];
        a_num_h     = {2'd0, a_hmag, 6'd0} - {6'd0, a_hmag, 2'd0};
        a_num_s     = {a_diff, 8'd0} - {8'd0, a_diff};
        a_den_s     = (a_sum <= 9'd255) ? a_sum[7:0] : a_inv[7:0];
        a_den_h     = a_diff;
        // Grey colors skip the divide; keep operands harmless
        if (a_side.gray) begin
            a_num_s = 16'd0;
            a_num_h = 16'd0;
            a_den_s = 8'd1;
            a_den_h = 8'd1;
        end
    end

    hsp_pkg::t_side r_b_side;
    logic [15:0]    r_b_num_s, r_b_num_h;
    logic [7:0]     r_b_den_s, r_b_den_h;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_side  <= a_side;
            r_b_num_s <= a_num_s;
            r_b_num_h <= a_num_h;
            r_b_den_s <= a_den_s;
            r_b_den_h <= a_den_h;
        end
    end

    // ---- Divider stages
    hsp_pkg::t_side w_d_side;
    logic [7:0]     w_qs, w_qh;

    hsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vb),
        .i_side  (r_b_side),
        .i_num_s (r_b_num_s),
        .i_den_s (r_b_den_s),
        .i_num_h (r_b_num_h),
        .i_den_h (r_b_den_h),
        .o_valid (w_vdiv),
        .o_side  (w_d_side),
        .o_quo_s (w_qs),
        .o_quo_h (w_qh)
    );

    // ---- Stage C: hue in degrees, wrapped to 0..359
    logic signed [9:0] d_h;
    logic [8:0]        d_hw;
    always_comb begin
        case (w_d_side.hbase)
            hsp_pkg::BASE_GREEN: d_h = 10'sd120;
            hsp_pkg::BASE_BLUE:  d_h = 10'sd240;
            default:             d_h = 10'sd0;
        endcase
        d_h  = w_d_side.hneg ? d_h - $signed({2'b0, w_qh}) : d_h + $signed({2'b0, w_qh});
        d_hw = d_h[9] ? 9'(d_h + 10'sd360) : d_h[8:0];
    end

    hsp_pkg::t_side r_c_side;
    logic [8:0]     r_c_h;
    logic [7:0]     r_c_s;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_side <= w_d_side;
            r_c_h    <= d_hw;
            r_c_s    <= w_qs;
        end
    end

    // ---- Stage D: apply scales
    hsp_pkg::t_side r_d_side;
    logic [16:0]    r_d_ph, r_d_pl;
    logic [15:0]    r_d_ps, r_d_pg;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_side <= r_c_side;
            r_d_ph   <= r_c_h * r_hue_scale;
            r_d_ps   <= r_c_s * r_sat_scale;
            r_d_pl   <= r_c_side.sum * r_light_scale;
            r_d_pg   <= r_c_side.red * r_light_scale;
        end
    end

    // ---- Stage E: divide products by 255
    logic [9:0] e_h, e_s, e_l, e_g;
    assign e_h = hsp_pkg::div255({1'b0, r_d_ph});
    assign e_s = hsp_pkg::div255({2'b0, r_d_ps});
    assign e_l = hsp_pkg::div255({1'b0, r_d_pl});
    assign e_g = hsp_pkg::div255({2'b0, r_d_pg});

    hsp_pkg::t_side r_e_side;
    logic [8:0]     r_e_h, r_e_l;
    logic [7:0]     r_e_s, r_e_grey;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_side <= r_d_side;
            r_e_h    <= e_h[8:0];
            r_e_s    <= e_s[7:0];
            r_e_l    <= e_l[8:0];
            r_e_grey <= e_g[7:0];
        end
    end

    // ---- Stage F: upper level numerator
    logic       f_high;
    logic [8:0] f_fac;
    assign f_high = (r_e_l > 9'd255);
    assign f_fac  = f_high ? 9'(9'd255 - {1'b0, r_e_s}) : 9'(9'd255 + {1'b0, r_e_s});

    hsp_pkg::t_side r_f_side;
    logic [17:0]    r_f_num;
    logic           r_f_high;
    logic [8:0]     r_f_h, r_f_l;
    logic [7:0]     r_f_s, r_f_grey;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_side <= r_e_side;
            r_f_num  <= r_e_l * f_fac;
            r_f_high <= f_high;
            r_f_h    <= r_e_h;
            r_f_l    <= r_e_l;
            r_f_s    <= r_e_s;
            r_f_grey <= r_e_grey;
        end
    end

    // ---- Stage G: upper level, hue angles per channel
    logic [9:0] g_q;
    logic [9:0] g_m2;
    logic [9:0] g_ar, g_ab;
    always_comb begin
        g_q  = hsp_pkg::div255({1'b0, r_f_num[17:1]});
        g_m2 = r_f_high ? g_q + {2'b0, r_f_s} : g_q;
        g_ar = {1'b0, r_f_h} + 10'd120;
        if (g_ar > 10'd360) begin
            g_ar = g_ar - 10'd360;
        end
        g_ab = (r_f_h < 9'd120) ? {1'b0, r_f_h} + 10'd240 : {1'b0, r_f_h} - 10'd120;
    end

    hsp_pkg::t_side r_g_side;
    logic [9:0]     r_g_m2;
    logic [8:0]     r_g_l;
    logic [8:0]     r_g_ang [3];
    logic [7:0]     r_g_grey;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_side   <= r_f_side;
            r_g_m2     <= g_m2;
            r_g_l      <= r_f_l;
            r_g_ang[0] <= g_ar[8:0];
            r_g_ang[1] <= r_f_h;
            r_g_ang[2] <= g_ab[8:0];
            r_g_grey   <= r_f_grey;
        end
    end

    // ---- Stage H: lower level, region and slope product per channel
    logic signed [11:0] h_m1, h_dd;
    logic [5:0]         h_t   [3];
    t_rgn               h_rgn [3];
    always_comb begin
        h_m1 = $signed({3'b0, r_g_l}) - $signed({2'b0, r_g_m2});
        h_dd = $signed({2'b0, r_g_m2}) - h_m1;
        for (int c = 0; c < 3; c++) begin
            if (r_g_ang[c] < 9'd60) begin
                h_rgn[c] = RGN_UP;
                h_t[c]   = r_g_ang[c][5:0];
            end else if (r_g_ang[c] < 9'd180) begin
                h_rgn[c] = RGN_HI;
                h_t[c]   = 6'd0;
            end else if (r_g_ang[c] < 9'd240) begin
                h_rgn[c] = RGN_DOWN;
                h_t[c]   = 6'(9'd240 - r_g_ang[c]);
            end else begin
                h_rgn[c] = RGN_LO;
                h_t[c]   = 6'd0;
            end
        end
    end

    hsp_pkg::t_side     r_h_side;
    logic signed [11:0] r_h_m1;
    logic [9:0]         r_h_m2;
    logic signed [17:0] r_h_prod [3];
    t_rgn               r_h_rgn  [3];
    logic [7:0]         r_h_grey;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_side <= r_g_side;
            r_h_m1   <= h_m1;
            r_h_m2   <= r_g_m2;
            r_h_grey <= r_g_grey;
            for (int c = 0; c < 3; c++) begin
                r_h_prod[c] <= 18'(h_dd * $signed({1'b0, h_t[c]}));
                r_h_rgn[c]  <= h_rgn[c];
            end
        end
    end

    // ---- Stage I: blend and output register
    logic signed [11:0] i_ch [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (r_h_rgn[c]) inside
                RGN_UP, RGN_DOWN: i_ch[c] = r_h_m1 + hsp_pkg::div60s(r_h_prod[c]);
                RGN_HI:           i_ch[c] = $signed({2'b0, r_h_m2});
                default:          i_ch[c] = r_h_m1;
            endcase
        end
    end

    logic [7:0] r_o_idx, r_o_red, r_o_green, r_o_blue;
    logic       r_o_last;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_idx   <= r_h_side.idx;
            r_o_last  <= r_h_side.last;
            r_o_red   <= r_h_side.gray ? r_h_grey : i_ch[0][7:0];
            r_o_green <= r_h_side.gray ? r_h_grey : i_ch[1][7:0];
            r_o_blue  <= r_h_side.gray ? r_h_grey : i_ch[2][7:0];
        end
    end

    // Advance valid bits along the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_vg <= 1'b0;
            r_vh <= 1'b0;
            r_vi <= 1'b0;
        end else if (en) begin
            r_va <= i_in_valid;
            r_vb <= r_va;
            r_vc <= w_vdiv;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vf <= r_ve;
            r_vg <= r_vf;
            r_vh <= r_vg;
            r_vi <= r_vh;
        end
    end

    assign o_out_valid = r_vi;
    assign o_out_index = r_o_idx;
    assign o_out_last  = r_o_last;
    assign o_out_red   = r_o_red;
    assign o_out_green = r_o_green;
    assign o_out_blue  = r_o_blue;

`ifndef SYNTH
    // A grey source leaves the pipeline with three equal channels
    a_grey_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vh && r_h_side.gray) |=>
            (o_out_red == o_out_green && o_out_green == o_out_blue))
        else $error("grey color produced unequal channels");

    // Nothing emerges in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("valid output right after reset");

    // A stalled output freezes the divider hand-off
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en) |=> $stable(r_vc) && $stable(r_c_h))
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== rtl/hsp_div.sv =====
// ---------------------------------------------------------------------------
// hsp_div: twin pipelined restoring divider, 16-bit by 8-bit
// Saturation and hue quotients, two bits per stage, sideband carried along.
// ---------------------------------------------------------------------------
module hsp_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  hsp_pkg::t_side       i_side,
    input  logic [15:0]          i_num_s,
    input  logic [7:0]           i_den_s,
    input  logic [15:0]          i_num_h,
    input  logic [7:0]           i_den_h,
    output logic                 o_valid,
    output hsp_pkg::t_side       o_side,
    output logic [7:0]           o_quo_s,
    output logic [7:0]           o_quo_h
);

    logic             r_vld  [hsp_pkg::DivStages];
    hsp_pkg::t_side   r_side [hsp_pkg::DivStages];
    hsp_pkg::t_dstep  r_st_s [hsp_pkg::DivStages];
    hsp_pkg::t_dstep  r_st_h [hsp_pkg::DivStages];
    logic [7:0]       r_den_s[hsp_pkg::DivStages];
    logic [7:0]       r_den_h[hsp_pkg::DivStages];

    // Quotient fits 8 bits, so the high byte starts as the remainder
    hsp_pkg::t_dstep  w_init_s, w_init_h;
    assign w_init_s = '{rem: i_num_s[15:8], low: i_num_s[7:0], quo: 8'd0};
    assign w_init_h = '{rem: i_num_h[15:8], low: i_num_h[7:0], quo: 8'd0};

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hsp_pkg::DivStages; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < hsp_pkg::DivStages; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Advance division state, two quotient bits per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0]  <= i_side;
            r_den_s[0] <= i_den_s;
            r_den_h[0] <= i_den_h;
            r_st_s[0]  <= hsp_pkg::div_two(w_init_s, i_den_s);
            r_st_h[0]  <= hsp_pkg::div_two(w_init_h, i_den_h);
            for (int k = 1; k < hsp_pkg::DivStages; k++) begin
                r_side[k]  <= r_side[k-1];
                r_den_s[k] <= r_den_s[k-1];
                r_den_h[k] <= r_den_h[k-1];
                r_st_s[k]  <= hsp_pkg::div_two(r_st_s[k-1], r_den_s[k-1]);
                r_st_h[k]  <= hsp_pkg::div_two(r_st_h[k-1], r_den_h[k-1]);
            end
        end
    end

    assign o_valid = r_vld[hsp_pkg::DivStages-1];
    assign o_side  = r_side[hsp_pkg::DivStages-1];
    assign o_quo_s = r_st_s[hsp_pkg::DivStages-1].quo;
    assign o_quo_h = r_st_h[hsp_pkg::DivStages-1].quo;

endmodule
